// ----- rtl/sbr_pkg.sv -----
`timescale 1ns / 1ps

package sbr_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_SKIP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_READ_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP_DONE = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;

  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [3:0] BYTE_BITS  = 4'd8;

  // Width of the bit counter for a field
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_READ = 2'd1,
    KIND_SKIP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_TAKE = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       byte_value;
    logic [CNT_W-1:0] bit_count;
    logic             drop_stuffing;
    logic [7:0]       target_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } out_item_t;

  // Bit counters handed to and from the shift unit
  typedef struct packed {
    logic [3:0]       bits_left;
    logic [CNT_W-1:0] wanted;
  } step_t;

endpackage

// ----- rtl/sbr_take_unit.sv -----
`timescale 1ns / 1ps

// Moves one bit from the current byte into the field value per use.
module sbr_take_unit #(
  parameter int VALUE_W = 32
) (
  input  logic [7:0]         cur_byte,
  input  sbr_pkg::step_t     step_in,
  input  logic [VALUE_W-1:0] value_in,
  output sbr_pkg::step_t     step_out,
  output logic [VALUE_W-1:0] value_out,
  output logic               more
);

  logic [2:0] bit_idx;

  assign bit_idx = 3'(step_in.bits_left - 4'd1);
  assign more    = (step_in.bits_left != 4'd0) && (step_in.wanted != '0);

  // Shift the next unread bit (msb first) into the value
  always_comb begin
    step_out  = step_in;
    value_out = value_in;
    if (more) begin
      value_out          = {value_in[VALUE_W-2:0], cur_byte[bit_idx]};
      step_out.bits_left = step_in.bits_left - 4'd1;
      step_out.wanted    = step_in.wanted - sbr_pkg::CNT_W'(1);
    end
  end

endmodule

// ----- rtl/stuffed_bitstream_bit_reader.sv -----
`timescale 1ns / 1ps
// Flow: a read request, or a byte a pending read takes as data, is accepted in the idle state;
//   the take state then moves one bit per cycle with the single one-bit shift unit (at most
//   8 bits per byte) and checks the field: a complete one goes to the emit state to load the output.
// Other items give no result or go straight to the emit state; no item is taken meanwhile.
// A result waits in the emit state for as long as out_stall holds the output register.
// Reset (rst_n low, synchronous): nothing pending, counters and flags cleared.
module stuffed_bitstream_bit_reader #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sbr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sbr_pkg::out_item_t out_item
);

  localparam logic [sbr_pkg::CNT_W-1:0] MAX_CNT = sbr_pkg::CNT_W'(MAX_FIELD_BITS);

  sbr_pkg::state_t state_r, state_nxt;
  sbr_pkg::kind_t  pending_r, pending_nxt;
  logic [7:0]                cur_byte_r, cur_byte_nxt;
  sbr_pkg::step_t            step_r, step_nxt;
  logic [MAX_FIELD_BITS-1:0] value_r, value_nxt;
  logic                      last_ff_r, last_ff_nxt;
  logic                      stuff_r, stuff_nxt;
  logic [7:0]                target_r, target_nxt;
  logic [1:0]                res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sbr_pkg::out_item_t        out_item_r, out_item_nxt;

  sbr_pkg::step_t            unit_step;
  logic [MAX_FIELD_BITS-1:0] unit_value;
  logic                      unit_more;
  logic                      in_acc;
  logic [sbr_pkg::CNT_W-1:0] sat_count;

  sbr_take_unit #(
    .VALUE_W(MAX_FIELD_BITS)
  ) u_take (
    .cur_byte (cur_byte_r),
    .step_in  (step_r),
    .value_in (value_r),
    .step_out (unit_step),
    .value_out(unit_value),
    .more     (unit_more)
  );

  assign in_stall  = (state_r != sbr_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign sat_count = (in_item.bit_count > MAX_CNT) ? MAX_CNT : in_item.bit_count;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    pending_nxt    = pending_r;
    cur_byte_nxt   = cur_byte_r;
    step_nxt       = step_r;
    value_nxt      = value_r;
    last_ff_nxt    = last_ff_r;
    stuff_nxt      = stuff_r;
    target_nxt     = target_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    case (state_r)
      sbr_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_item.req_type == sbr_pkg::REQ_BYTE) begin
            case (pending_r)
              sbr_pkg::KIND_READ: begin
                if (last_ff_r && stuff_r && (in_item.byte_value == 8'd0)) begin
                  // stuffed zero after 0xFF: drop it
                  last_ff_nxt = 1'b0;
                end else begin
                  cur_byte_nxt       = in_item.byte_value;
                  step_nxt.bits_left = sbr_pkg::BYTE_BITS;
                  last_ff_nxt        = (in_item.byte_value == sbr_pkg::STUFF_BYTE);
                  state_nxt          = sbr_pkg::S_TAKE;
                end
              end
              sbr_pkg::KIND_SKIP: begin
                if (in_item.byte_value == target_r) begin
                  cur_byte_nxt       = in_item.byte_value;
                  step_nxt.bits_left = sbr_pkg::BYTE_BITS;
                  pending_nxt        = sbr_pkg::KIND_NONE;
                  res_status_nxt     = sbr_pkg::ST_SKIP_DONE;
                  state_nxt          = sbr_pkg::S_EMIT;
                end
              end
              default: begin
                res_status_nxt = sbr_pkg::ST_IGNORED;
                state_nxt      = sbr_pkg::S_EMIT;
              end
            endcase
          end else if (pending_r != sbr_pkg::KIND_NONE ||
                       !(in_item.req_type inside {sbr_pkg::REQ_READ, sbr_pkg::REQ_SKIP})) begin
            res_status_nxt = sbr_pkg::ST_IGNORED;
            state_nxt      = sbr_pkg::S_EMIT;
          end else if (in_item.req_type == sbr_pkg::REQ_READ) begin
            step_nxt.wanted = sat_count;
            value_nxt       = '0;
            stuff_nxt       = in_item.drop_stuffing;
            state_nxt       = sbr_pkg::S_TAKE;
          end else begin
            target_nxt  = in_item.target_byte;
            pending_nxt = sbr_pkg::KIND_SKIP;
          end
        end
      end
      sbr_pkg::S_TAKE: begin
        // one bit per cycle until byte empty or field complete
        if (unit_more) begin
          step_nxt  = unit_step;
          value_nxt = unit_value;
        end else if (step_r.wanted == '0) begin
          pending_nxt    = sbr_pkg::KIND_NONE;
          res_status_nxt = sbr_pkg::ST_READ_DONE;
          state_nxt      = sbr_pkg::S_EMIT;
        end else begin
          pending_nxt = sbr_pkg::KIND_READ;
          state_nxt   = sbr_pkg::S_IDLE;
        end
      end
      sbr_pkg::S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.status     = res_status_r;
          out_item_nxt.read_value = (res_status_r == sbr_pkg::ST_READ_DONE) ?
                                    32'(value_r) : 32'd0;
          state_nxt               = sbr_pkg::S_IDLE;
        end
      end
      default: state_nxt = sbr_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbr_pkg::S_IDLE;
      pending_r   <= sbr_pkg::KIND_NONE;
      step_r      <= '0;
      last_ff_r   <= 1'b0;
      stuff_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      step_r      <= step_nxt;
      last_ff_r   <= last_ff_nxt;
      stuff_r     <= stuff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cur_byte_r   <= cur_byte_nxt;
    value_r      <= value_nxt;
    target_r     <= target_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
  end

  // Checks
  a_bits_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r.bits_left <= sbr_pkg::BYTE_BITS)
    else $error("bits_left above one byte");

  a_wanted_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r.wanted <= MAX_CNT)
    else $error("wanted count above field limit");

  a_no_skip_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sbr_pkg::S_TAKE |-> pending_r != sbr_pkg::KIND_SKIP)
    else $error("shift unit running during a skip");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbr_pkg::S_EMIT && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == sbr_pkg::S_IDLE))
    else $error("result not loaded on emit");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int FIELD_MAX = 32;
  localparam int WORK_ITEMS = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 24;
  localparam logic [1:0] REQ_BAD = 2'd3;

  // Tracks the reader state and the fields each accepted item should produce
  class bitreader_checker;
    logic [7:0] cur_byte;
    logic [3:0] bits_left;
    bit last_ff;
    sbr_pkg::kind_t kind;
    logic [5:0] wanted;
    logic [31:0] acc;
    bit stuff_mode;
    logic [7:0] skip_tgt;
    sbr_pkg::out_item_t fields_due[$];
    int errors;

    function new();
      cur_byte = '0;
      bits_left = '0;
      last_ff = 1'b0;
      kind = sbr_pkg::KIND_NONE;
      wanted = '0;
      acc = '0;
      stuff_mode = 1'b0;
      skip_tgt = '0;
      errors = 0;
    endfunction

    // Move up to min(bits_left, wanted) bits from the current byte into acc
    function void shift_bits();
      int n;
      n = (bits_left < wanted) ? bits_left : wanted;
      if (n == 0) return;
      acc = (acc << n) | ((32'(cur_byte) >> (bits_left - n)) & ((32'd1 << n) - 1));
      bits_left = bits_left - 4'(n);
      cur_byte = cur_byte & 8'((32'd1 << bits_left) - 1);
      wanted = wanted - 6'(n);
    endfunction

    // Advance the reader by one item; returns 1 when a result is due
    function bit advance_reader(sbr_pkg::in_item_t it, output sbr_pkg::out_item_t res);
      res = '0;
      if (it.req_type == sbr_pkg::REQ_BYTE) begin
        if (kind == sbr_pkg::KIND_READ) begin
          // stuffed zero after 0xFF is dropped and clears the flag
          if (last_ff && stuff_mode && it.byte_value == 8'h00) begin
            last_ff = 1'b0;
            return 1'b0;
          end
          cur_byte = it.byte_value;
          bits_left = sbr_pkg::BYTE_BITS;
          last_ff = (it.byte_value == sbr_pkg::STUFF_BYTE);
          shift_bits();
          if (wanted == 0) begin
            kind = sbr_pkg::KIND_NONE;
            res.status = sbr_pkg::ST_READ_DONE;
            res.read_value = acc;
            return 1'b1;
          end
          return 1'b0;
        end
        if (kind == sbr_pkg::KIND_SKIP) begin
          // target byte kept whole; 0xFF memory untouched
          if (it.byte_value == skip_tgt) begin
            cur_byte = it.byte_value;
            bits_left = sbr_pkg::BYTE_BITS;
            kind = sbr_pkg::KIND_NONE;
            res.status = sbr_pkg::ST_SKIP_DONE;
            return 1'b1;
          end
          return 1'b0;
        end
        res.status = sbr_pkg::ST_IGNORED;
        return 1'b1;
      end
      if (it.req_type == REQ_BAD || kind != sbr_pkg::KIND_NONE) begin
        res.status = sbr_pkg::ST_IGNORED;
        return 1'b1;
      end
      if (it.req_type == sbr_pkg::REQ_READ) begin
        wanted = (it.bit_count > FIELD_MAX) ? 6'(FIELD_MAX) : it.bit_count;
        acc = '0;
        stuff_mode = it.drop_stuffing;
        shift_bits();
        if (wanted == 0) begin
          res.status = sbr_pkg::ST_READ_DONE;
          res.read_value = acc;
          return 1'b1;
        end
        kind = sbr_pkg::KIND_READ;
        return 1'b0;
      end
      skip_tgt = it.target_byte;
      kind = sbr_pkg::KIND_SKIP;
      return 1'b0;
    endfunction

    function void note_item(sbr_pkg::in_item_t it);
      sbr_pkg::out_item_t res;
      if (advance_reader(it, res)) fields_due.push_back(res);
    endfunction

    function void check_result(sbr_pkg::out_item_t got);
      sbr_pkg::out_item_t want;
      if (fields_due.size() == 0) begin
        $error("unexpected result: status %0d read_value %h", got.status, got.read_value);
        errors++;
        return;
      end
      want = fields_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (fields_due.size() != 0) begin
        $error("%0d results never arrived", fields_due.size());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sbr_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sbr_pkg::out_item_t out_item;

  bitreader_checker sb = new();
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  stuffed_bitstream_bit_reader #(
    .MAX_FIELD_BITS(FIELD_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Item builders: unused fields carry random bits
  function automatic sbr_pkg::in_item_t rand_item();
    sbr_pkg::in_item_t it;
    it.req_type = 2'($urandom);
    it.byte_value = 8'($urandom);
    it.bit_count = 6'($urandom);
    it.drop_stuffing = 1'($urandom);
    it.target_byte = 8'($urandom);
    return it;
  endfunction

  function automatic sbr_pkg::in_item_t byte_item(logic [7:0] b);
    sbr_pkg::in_item_t it;
    it = rand_item();
    it.req_type = sbr_pkg::REQ_BYTE;
    it.byte_value = b;
    return it;
  endfunction

  function automatic sbr_pkg::in_item_t read_item(int cnt, bit drop);
    sbr_pkg::in_item_t it;
    it = rand_item();
    it.req_type = sbr_pkg::REQ_READ;
    it.bit_count = 6'(cnt);
    it.drop_stuffing = drop;
    return it;
  endfunction

  function automatic sbr_pkg::in_item_t skip_item(logic [7:0] tgt);
    sbr_pkg::in_item_t it;
    it = rand_item();
    it.req_type = sbr_pkg::REQ_SKIP;
    it.target_byte = tgt;
    return it;
  endfunction

  // Stream bytes lean on 0xFF and 0x00 to hit the stuffing logic
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return sbr_pkg::STUFF_BYTE;
    if (r == 2) return 8'h00;
    return 8'($urandom);
  endfunction

  // Offer one item, wait for acceptance, then maybe idle
  task automatic offer(sbr_pkg::in_item_t it);
    int r;
    int gap;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.fields_due.size() != 0);
  endtask

  task automatic directed_items();
    offer(byte_item(8'h00));          // byte with nothing pending
    offer(read_item(0, 1'b0));        // zero-length read
    offer(read_item(8, 1'b0));
    offer(byte_item(8'hA5));
    offer(read_item(4, 1'b1));
    offer(byte_item(8'hFF));          // leaves four unread bits
    offer(read_item(12, 1'b1));       // leftover bits first
    offer(byte_item(8'h00));          // stuffed zero dropped
    offer(byte_item(8'h3C));
    offer(read_item(63, 1'b0));       // count saturates
    offer(read_item(5, 1'b1));        // request while busy
    offer(skip_item(8'hAA));          // request while busy
    offer(rand_item() | {REQ_BAD, 23'd0});
    offer(byte_item(8'hFF));
    offer(byte_item(8'h00));          // kept: stuffing removal off
    offer(byte_item(8'h12));
    offer(byte_item(8'h34));
    offer(read_item(8, 1'b1));
    offer(byte_item(8'hFF));
    offer(skip_item(8'h00));          // skip keeps the 0xFF memory
    offer(byte_item(8'h7E));
    offer(byte_item(8'h00));
    offer(read_item(12, 1'b1));
    offer(byte_item(8'h00));          // dropped: memory survived the skip
    offer(byte_item(8'hFF));
    offer(skip_item(8'hFF));
    offer(byte_item(8'hFF));
  endtask

  // Mostly complete read and skip sequences, with some noise mixed in
  task automatic random_items();
    int work;
    int r;
    int cnt;
    bit hold_done;
    bit drain_done;
    logic [7:0] tgt;
    sbr_pkg::in_item_t it;
    work = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    while (work < WORK_ITEMS) begin
      if (work >= 150 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (work >= 320 && !drain_done) begin
        drain();
        drain_done = 1'b1;
      end
      no_idle = (work >= 220 && work < 280);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // noise: stray byte, unknown request or anything at all
        case ($urandom_range(0, 2))
          0: it = byte_item(8'($urandom));
          1: begin
            it = rand_item();
            it.req_type = REQ_BAD;
          end
          default: it = rand_item();
        endcase
        offer(it);
        work++;
      end else if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 80) cnt = $urandom_range(0, 16);
        else if (r < 95) cnt = $urandom_range(17, FIELD_MAX);
        else cnt = $urandom_range(FIELD_MAX + 1, 63);
        offer(read_item(cnt, 1'($urandom)));
        work++;
        while (sb.kind != sbr_pkg::KIND_NONE) begin
          if ($urandom_range(0, 29) == 0) begin
            it = rand_item();
            it.req_type = $urandom_range(0, 1) ? sbr_pkg::REQ_READ : sbr_pkg::REQ_SKIP;
            offer(it);
          end else begin
            offer(byte_item(pick_byte()));
          end
          work++;
        end
      end else begin
        tgt = pick_byte();
        offer(skip_item(tgt));
        work++;
        while (sb.kind != sbr_pkg::KIND_NONE) begin
          offer(byte_item(($urandom_range(0, 3) == 0) ? tgt : pick_byte()));
          work++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Stimulus and end of run
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    drain();
    random_items();
    in_valid <= 1'b0;
    while (sb.fields_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: check at the edge, then pick the next stall
  initial begin : rx_side
    int stall_left;
    int hold_left;
    int r;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sbr_pkg.sv
rtl/sbr_take_unit.sv
rtl/stuffed_bitstream_bit_reader.sv
tb/tb_top.sv
